[hw/rtl/dssm_pkg.sv]
// Shared types and codes for the two-stacks-in-one-memory block.
package dssm_pkg;

	// Command codes; bit 0 selects stack Y for every defined command.
	localparam logic [2:0] CMD_PUSH_X = 3'd0;
	localparam logic [2:0] CMD_PUSH_Y = 3'd1;
	localparam logic [2:0] CMD_POP_X  = 3'd2;
	localparam logic [2:0] CMD_POP_Y  = 3'd3;
	localparam logic [2:0] CMD_LIST_X = 3'd4;
	localparam logic [2:0] CMD_LIST_Y = 3'd5;

	// Result status codes.
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_OVER  = 2'd1;
	localparam logic [1:0] STS_UNDER = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] push_value;
	} cmd_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic               last;
	} result_t;

endpackage

[hw/rtl/dual_stack_shared_memory.sv]
// Top level: two stacks sharing one RAM, with the command sequencer and output register.
//
//   channel | direction | payload         | handshake
//   --------+-----------+-----------------+---------------------
//   in      | input     | cmd_in_t        | in_valid / in_ready
//   out     | output    | result_t        | out_valid / out_ready
//
// For a push or pop, the accept cycle does the RAM write or issues the RAM read,
// and the emit state loads the result beat. A list makes one RAM read and one
// result beat per stored word. Unused command codes are accepted with no result.
// Reset clears both counts, the sequencer and the output valid; the RAM is not cleared.
// A stalled output holds the sequencer in its emit state; a new command is taken
// in idle even while the last result beat still waits in the output register.
module dual_stack_shared_memory #(
	parameter int STACK_DEPTH = 8,
	parameter int WORD_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dssm_pkg::cmd_in_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dssm_pkg::result_t out_data
);

	import dssm_pkg::*;

	localparam int STORE_WORDS = 2 * STACK_DEPTH;
	localparam int AW = $clog2(STORE_WORDS);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_x_q, cnt_y_q;
	logic [CW-1:0]    idx_q;
	logic             is_y_q, list_q, use_data_q;
	logic [1:0]       status_q;
	result_t          out_q;
	logic             out_valid_q;

	logic             acc, out_free, more;
	logic             is_y_in, go;
	logic [CW-1:0]    cur_cnt, cnt_m1, nxt_idx;
	logic [CW-1:0]    cnt_x_d, cnt_y_d;
	logic [1:0]       dec_status;
	logic             dec_use, dec_list;
	logic             wr_en, rd_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [WORD_WIDTH-1:0] wr_data, rd_data;

	function automatic logic [AW-1:0] addr_of(input logic y, input logic [CW-1:0] pos);
		logic [AW-1:0] p;
		p = AW'(pos);
		return y ? (AW'(STORE_WORDS - 1) - p) : p;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_y_in = in_data.command[0];
	assign cur_cnt = is_y_in ? cnt_y_q : cnt_x_q;
	assign cnt_m1  = cur_cnt - CW'(1);
	assign nxt_idx = idx_q - CW'(1);
	assign more    = list_q && (idx_q != '0);

	// Command decode and RAM access. Only one access per cycle is ever issued:
	// the accept cycle of a command and each emit cycle are disjoint.
	always_comb begin
		go         = 1'b0;
		dec_status = STS_OK;
		dec_use    = 1'b0;
		dec_list   = 1'b0;
		cnt_x_d    = cnt_x_q;
		cnt_y_d    = cnt_y_q;
		wr_en      = 1'b0;
		wr_addr    = addr_of(is_y_in, cur_cnt);
		wr_data    = WORD_WIDTH'(in_data.push_value);
		rd_en      = 1'b0;
		rd_addr    = addr_of(is_y_in, cnt_m1);
		if (state_q == ST_IDLE) begin
			case (in_data.command)
				CMD_PUSH_X, CMD_PUSH_Y: begin
					go = acc;
					if (cur_cnt == CW'(STACK_DEPTH)) begin
						dec_status = STS_OVER;
					end else begin
						wr_en = acc;
						if (is_y_in) cnt_y_d = cur_cnt + CW'(1);
						else         cnt_x_d = cur_cnt + CW'(1);
					end
				end
				CMD_POP_X, CMD_POP_Y: begin
					go = acc;
					if (cur_cnt == '0) begin
						dec_status = STS_UNDER;
					end else begin
						rd_en   = acc;
						dec_use = 1'b1;
						if (is_y_in) cnt_y_d = cnt_m1;
						else         cnt_x_d = cnt_m1;
					end
				end
				CMD_LIST_X, CMD_LIST_Y: begin
					go = acc;
					if (cur_cnt == '0) begin
						dec_status = STS_UNDER;
					end else begin
						rd_en    = acc;
						dec_use  = 1'b1;
						dec_list = 1'b1;
					end
				end
				default: go = 1'b0;
			endcase
		end else if (state_q == ST_EMIT && out_free && more) begin
			// Fetch the next word down while the current one leaves.
			rd_en   = 1'b1;
			rd_addr = addr_of(is_y_q, nxt_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_x_q     <= '0;
			cnt_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_x_q <= cnt_x_d;
						cnt_y_q <= cnt_y_d;
					end
					if (go) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free && !more) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			is_y_q     <= is_y_in;
			status_q   <= dec_status;
			use_data_q <= dec_use;
			list_q     <= dec_list;
			idx_q      <= cnt_m1;
		end else if (state_q == ST_EMIT && out_free && more) begin
			idx_q <= nxt_idx;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q.status <= status_q;
			out_q.value  <= use_data_q ? 32'($signed(rd_data)) : '0;
			out_q.last   <= !more;
		end
	end

	dssm_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(STORE_WORDS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// The RAM never sees a read and a write in the same cycle.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("RAM read and write issued together");

	// A push into a full stack X leaves its count untouched.
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.command == CMD_PUSH_X && cnt_x_q == CW'(STACK_DEPTH))
		|=> $stable(cnt_x_q))
		else $error("count changed on overflowing push");

	// While listing, the word being fetched lies below the stack's count.
	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && list_q) |-> (idx_q < (is_y_q ? cnt_y_q : cnt_x_q)))
		else $error("list index beyond stack count");

	// The beat flagged last returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && !more) |=> (state_q == ST_IDLE && out_q.last))
		else $error("sequencer did not finish after last beat");

endmodule

[hw/rtl/dssm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module dssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
